[rtl/core/vfdu_pkg.sv]
package vfdu_pkg;

	localparam int WordW             = 32;
	localparam int PosW              = 25;
	localparam int BufW              = 2 * WordW;
	localparam int CntW              = 7;
	localparam int SampLeftW         = 31;
	localparam int BpsW              = 6;
	localparam int BpsFieldW         = 5;
	localparam int DividendW         = PosW + 5;
	localparam int DivCntW           = 5;
	localparam int MaxSamplesPerWord = 32;
	localparam int RunW              = 6;
	localparam int FifoDepth         = 2;
	localparam int FifoPtrW          = 1;
	localparam int FifoCntW          = 2;
	localparam int HdrLegacyLen      = 4;
	localparam int HdrFullLen        = 8;
	localparam logic [7:0] EdvVersion = 8'h01;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_HEADER,
		KIND_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_COMPLEX,
		ERR_MULTICHAN,
		ERR_EDV
	} err_t;

	typedef enum logic [1:0] {
		BK_FETCH,
		BK_DIV,
		BK_HDR,
		BK_UNPACK
	} back_state_t;

	typedef struct packed {
		logic [29:0] epoch_seconds;
		logic [23:0] frame_index;
		logic [5:0]  epoch_code;
		logic [9:0]  thread_number;
		logic [15:0] station_code;
		logic        invalid_flag;
		logic        legacy_flag;
	} hdr_t;

	// one queue entry: either a finished header or a payload word
	typedef struct packed {
		logic                 is_hdr;
		logic                 frame_last;
		logic [WordW-1:0]     word;
		err_t                 err;
		logic [PosW-1:0]      pay_words;
		logic [BpsFieldW-1:0] bps_m1;
		hdr_t                 hdr;
	} cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic [WordW-1:0] sample_value;
		logic             last_of_run;
		logic             end_of_frame;
		hdr_t             hdr;
		err_t             error_code;
	} res_t;

endpackage

[rtl/core/vfdu_fifo.sv]
module vfdu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vfdu_pkg::cmd_t push_data,
	input  logic          pop,
	output vfdu_pkg::cmd_t pop_data,
	output logic          full,
	output logic          empty
);

	vfdu_pkg::cmd_t                      entry_q [vfdu_pkg::FifoDepth];
	logic [vfdu_pkg::FifoPtrW-1:0] wr_ptr_q;
	logic [vfdu_pkg::FifoPtrW-1:0] rd_ptr_q;
	logic [vfdu_pkg::FifoCntW-1:0] count_q;

	assign full     = (count_q == vfdu_pkg::FifoCntW'(vfdu_pkg::FifoDepth));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

[rtl/core/vfdu_front.sv]
module vfdu_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [vfdu_pkg::WordW-1:0]  data_word,
	input  logic                        q_full,
	output logic                        in_stall,
	output logic                        push,
	output vfdu_pkg::cmd_t              push_data
);

	logic [vfdu_pkg::PosW-1:0]  pos_q;
	logic [vfdu_pkg::PosW-1:0]  frame_words_q;
	logic [vfdu_pkg::WordW-1:0] hw0_q;
	logic [vfdu_pkg::WordW-1:0] hw1_q;
	logic [vfdu_pkg::WordW-1:0] hw2_q;
	logic [vfdu_pkg::WordW-1:0] hw3_q;
	logic                       legacy_q;
	logic                       skip_q;

	logic                       accept;
	logic [vfdu_pkg::PosW-1:0]  hdr_len;
	logic [vfdu_pkg::PosW-1:0]  frame_end_pos;
	logic                       finish_legacy;
	logic                       finish_full;
	logic                       finish;
	logic                       payload;
	logic                       frame_end;
	logic [vfdu_pkg::WordW-1:0] w3;
	vfdu_pkg::err_t             err;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		hdr_len = legacy_q ? vfdu_pkg::PosW'(vfdu_pkg::HdrLegacyLen)
		                   : vfdu_pkg::PosW'(vfdu_pkg::HdrFullLen);
		frame_end_pos = (frame_words_q > hdr_len) ? frame_words_q : hdr_len;
		finish_legacy = (pos_q == vfdu_pkg::PosW'(3)) && legacy_q;
		finish_full   = (pos_q == vfdu_pkg::PosW'(4)) && !legacy_q;
		finish        = finish_legacy || finish_full;
		payload       = (pos_q >= hdr_len) && !skip_q;
		frame_end     = (pos_q >= vfdu_pkg::PosW'(3))
			&& (({1'b0, pos_q} + 1'b1) >= {1'b0, frame_end_pos});
		w3 = legacy_q ? data_word : hw3_q;

		// complex first, then multichannel, then extended data version
		if (w3[31]) begin
			err = vfdu_pkg::ERR_COMPLEX;
		end else if (hw2_q[28:24] != 5'd0) begin
			err = vfdu_pkg::ERR_MULTICHAN;
		end else if (!legacy_q && (data_word[31:24] != vfdu_pkg::EdvVersion)) begin
			err = vfdu_pkg::ERR_EDV;
		end else begin
			err = vfdu_pkg::ERR_NONE;
		end

		push_data.is_hdr     = finish;
		push_data.frame_last = frame_end;
		push_data.word       = data_word;
		push_data.err        = err;
		push_data.pay_words  = (frame_words_q > hdr_len) ? (frame_words_q - hdr_len) : '0;
		push_data.bps_m1     = w3[30:26];
		push_data.hdr.epoch_seconds = hw0_q[29:0];
		push_data.hdr.frame_index   = hw1_q[23:0];
		push_data.hdr.epoch_code    = hw1_q[29:24];
		push_data.hdr.thread_number = w3[25:16];
		push_data.hdr.station_code  = w3[15:0];
		push_data.hdr.invalid_flag  = hw0_q[31];
		push_data.hdr.legacy_flag   = hw0_q[30];

		push = accept && (finish || payload);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			frame_words_q <= '0;
			hw0_q         <= '0;
			hw1_q         <= '0;
			hw2_q         <= '0;
			hw3_q         <= '0;
			legacy_q      <= 1'b0;
			skip_q        <= 1'b0;
		end else if (accept) begin
			case (pos_q)
				vfdu_pkg::PosW'(0): begin
					hw0_q    <= data_word;
					legacy_q <= data_word[30];
				end
				vfdu_pkg::PosW'(1): begin
					hw1_q <= data_word;
				end
				vfdu_pkg::PosW'(2): begin
					hw2_q         <= data_word;
					frame_words_q <= {data_word[23:0], 1'b0};
				end
				vfdu_pkg::PosW'(3): begin
					hw3_q <= data_word;
				end
				default: begin
				end
			endcase
			if (finish) begin
				skip_q <= (err != vfdu_pkg::ERR_NONE);
			end
			if (frame_end) begin
				pos_q  <= '0;
				skip_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q >= vfdu_pkg::PosW'(4)) |-> (pos_q < frame_end_pos))
		else $error("word position ran past the frame end");

endmodule

[rtl/core/vfdu_div.sv]
module vfdu_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [vfdu_pkg::DividendW-1:0]  dividend,
	input  logic [vfdu_pkg::BpsW-1:0]       divisor,
	output logic                            done,
	output logic [vfdu_pkg::DividendW-1:0]  quotient
);

	logic [vfdu_pkg::DividendW-1:0] quo_q;
	logic [vfdu_pkg::BpsW-1:0]      rem_q;
	logic [vfdu_pkg::BpsW-1:0]      div_q;
	logic [vfdu_pkg::DivCntW-1:0]   step_q;
	logic                           busy_q;
	logic                           done_q;

	logic [vfdu_pkg::BpsW:0]        trial;
	logic                           qbit;
	logic [vfdu_pkg::BpsW-1:0]      rem_d;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[vfdu_pkg::DividendW-1]};
		qbit  = (trial >= {1'b0, div_q});
		rem_d = qbit ? vfdu_pkg::BpsW'(trial - {1'b0, div_q})
		             : trial[vfdu_pkg::BpsW-1:0];
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
				step_q <= vfdu_pkg::DivCntW'(vfdu_pkg::DividendW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[vfdu_pkg::DividendW-2:0], qbit};
				rem_q <= rem_d;
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/vfdu_back.sv]
module vfdu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  vfdu_pkg::cmd_t cmd,
	output logic           pop,
	input  logic           out_stall,
	output logic           out_valid,
	output vfdu_pkg::res_t res
);

	vfdu_pkg::back_state_t          state_q;
	vfdu_pkg::back_state_t          state_d;
	logic [vfdu_pkg::SampLeftW-1:0] samples_left_q;
	logic [vfdu_pkg::BpsW-1:0]      bps_q;
	logic [vfdu_pkg::BufW-1:0]      buf_q;
	logic [vfdu_pkg::CntW-1:0]      cnt_q;
	logic [vfdu_pkg::RunW-1:0]      nrun_q;
	logic                           frame_last_q;
	vfdu_pkg::hdr_t                 hdr_q;
	vfdu_pkg::err_t                 err_q;
	logic                           out_valid_q;
	vfdu_pkg::res_t                 res_q;

	logic                           out_free;
	logic                           div_start;
	logic                           div_done;
	logic [vfdu_pkg::DividendW-1:0] div_quo;
	logic                           load_hdr;
	logic                           load_smp;
	logic [vfdu_pkg::BufW-1:0]      mask;
	logic [vfdu_pkg::CntW-1:0]      cnt_after;
	logic [vfdu_pkg::SampLeftW-1:0] sl_after;
	logic                           more;
	logic                           clamp;
	logic [vfdu_pkg::CntW-1:0]      shift_amt;
	logic [vfdu_pkg::BufW-1:0]      buf_next;
	logic [vfdu_pkg::CntW-1:0]      cnt_next;
	vfdu_pkg::res_t                 res_d;

	vfdu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({cmd.pay_words, 5'b0}),
		.divisor  (vfdu_pkg::BpsW'(cmd.bps_m1) + 1'b1),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// one sample step of the unpack loop
	always_comb begin
		mask      = (vfdu_pkg::BufW'(1) << bps_q) - vfdu_pkg::BufW'(1);
		cnt_after = cnt_q - vfdu_pkg::CntW'(bps_q);
		sl_after  = samples_left_q - 1'b1;
		more      = (sl_after != '0) && (cnt_after >= vfdu_pkg::CntW'(bps_q))
			&& ((nrun_q + 1'b1) < vfdu_pkg::RunW'(vfdu_pkg::MaxSamplesPerWord));
		// drop oldest bits when more than a word is left over after the run
		clamp     = !more && (cnt_after > vfdu_pkg::CntW'(vfdu_pkg::WordW));
		shift_amt = clamp ? (cnt_q - vfdu_pkg::CntW'(vfdu_pkg::WordW))
		                  : vfdu_pkg::CntW'(bps_q);
		if (sl_after == '0) begin
			buf_next = '0;
			cnt_next = '0;
		end else begin
			buf_next = buf_q >> shift_amt;
			cnt_next = clamp ? vfdu_pkg::CntW'(vfdu_pkg::WordW) : cnt_after;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		load_hdr  = 1'b0;
		load_smp  = 1'b0;
		case (state_q)
			vfdu_pkg::BK_FETCH: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (cmd.is_hdr) begin
						if (cmd.err == vfdu_pkg::ERR_NONE) begin
							div_start = 1'b1;
							state_d   = vfdu_pkg::BK_DIV;
						end else begin
							state_d = vfdu_pkg::BK_HDR;
						end
					end else if (samples_left_q != '0) begin
						state_d = vfdu_pkg::BK_UNPACK;
					end
				end
			end
			vfdu_pkg::BK_DIV: begin
				if (div_done) begin
					state_d = vfdu_pkg::BK_HDR;
				end
			end
			vfdu_pkg::BK_HDR: begin
				if (out_free) begin
					load_hdr = 1'b1;
					state_d  = vfdu_pkg::BK_FETCH;
				end
			end
			vfdu_pkg::BK_UNPACK: begin
				if (out_free) begin
					load_smp = 1'b1;
					if (!more) begin
						state_d = vfdu_pkg::BK_FETCH;
					end
				end
			end
			default: begin
				state_d = vfdu_pkg::BK_FETCH;
			end
		endcase
	end

	always_comb begin
		res_d = '0;
		if (load_hdr) begin
			res_d.kind         = (err_q == vfdu_pkg::ERR_NONE) ? vfdu_pkg::KIND_HEADER
			                                                   : vfdu_pkg::KIND_ERROR;
			res_d.last_of_run  = 1'b1;
			res_d.end_of_frame = (err_q != vfdu_pkg::ERR_NONE) || (samples_left_q == '0);
			res_d.hdr          = hdr_q;
			res_d.error_code   = err_q;
		end else begin
			res_d.kind         = vfdu_pkg::KIND_SAMPLE;
			res_d.sample_value = buf_q[vfdu_pkg::WordW-1:0] & mask[vfdu_pkg::WordW-1:0];
			res_d.last_of_run  = !more;
			res_d.end_of_frame = (sl_after == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfdu_pkg::BK_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_left_q <= '0;
			bps_q          <= vfdu_pkg::BpsW'(1);
			buf_q          <= '0;
			cnt_q          <= '0;
			nrun_q         <= '0;
			frame_last_q   <= 1'b0;
			hdr_q          <= '0;
			err_q          <= vfdu_pkg::ERR_NONE;
			out_valid_q    <= 1'b0;
			res_q          <= '0;
		end else begin
			if (pop && cmd.is_hdr) begin
				hdr_q          <= cmd.hdr;
				err_q          <= cmd.err;
				bps_q          <= vfdu_pkg::BpsW'(cmd.bps_m1) + 1'b1;
				samples_left_q <= '0;
				buf_q          <= '0;
				cnt_q          <= '0;
			end else if (pop && (samples_left_q != '0)) begin
				buf_q        <= buf_q | (vfdu_pkg::BufW'(cmd.word) << cnt_q);
				cnt_q        <= cnt_q + vfdu_pkg::CntW'(vfdu_pkg::WordW);
				nrun_q       <= '0;
				frame_last_q <= cmd.frame_last;
			end
			if (div_done) begin
				samples_left_q <= vfdu_pkg::SampLeftW'(div_quo);
			end
			if (load_smp) begin
				nrun_q <= nrun_q + 1'b1;
				// frame over: whatever is left is dropped
				if (!more && frame_last_q) begin
					samples_left_q <= '0;
					buf_q          <= '0;
					cnt_q          <= '0;
				end else begin
					samples_left_q <= sl_after;
					buf_q          <= buf_next;
					cnt_q          <= cnt_next;
				end
			end
			if (load_hdr || load_smp) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_unpack_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vfdu_pkg::BK_UNPACK) |-> (samples_left_q != '0))
		else $error("unpack running with no samples left");

	a_enough_bits: assert property (@(posedge clk) disable iff (!arst_n)
		load_smp |-> (cnt_q >= vfdu_pkg::CntW'(bps_q)))
		else $error("sample taken from too few buffered bits");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == vfdu_pkg::BK_DIV))
		else $error("division finished outside its wait state");

endmodule

[rtl/core/vdif_frame_deframer_unpacker.sv]
// VDIF deframer and sample unpacker. One 32-bit stream word is taken per accepted input
// item; each frame's header (4 words in legacy mode, 8 otherwise) gives one header or
// header-error result, then the payload is unpacked LSB first into samples of bps bits.
// The front end classifies words and queues headers and payload words in a two-entry
// queue; the back end turns them into results through a one-entry output register.
// Each payload word gives one result per sample (up to 32 with 1-bit samples); a good
// header waits on the one-bit-per-cycle divider that works out the frame's sample
// count, and an error header does not. The input stalls only while the queue is full.
module vdif_frame_deframer_unpacker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] sample_value,
	output logic        last_of_run,
	output logic        end_of_frame,
	output logic [29:0] epoch_seconds,
	output logic [23:0] frame_index,
	output logic [5:0]  epoch_code,
	output logic [9:0]  thread_number,
	output logic [15:0] station_code,
	output logic        invalid_flag,
	output logic        legacy_flag,
	output logic [1:0]  error_code
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	vfdu_pkg::cmd_t push_data;
	vfdu_pkg::cmd_t pop_data;
	vfdu_pkg::res_t res;

	vfdu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_word (data_word),
		.q_full    (q_full),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data)
	);

	vfdu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	vfdu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.cmd       (pop_data),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	assign kind          = res.kind;
	assign sample_value  = res.sample_value;
	assign last_of_run   = res.last_of_run;
	assign end_of_frame  = res.end_of_frame;
	assign epoch_seconds = res.hdr.epoch_seconds;
	assign frame_index   = res.hdr.frame_index;
	assign epoch_code    = res.hdr.epoch_code;
	assign thread_number = res.hdr.thread_number;
	assign station_code  = res.hdr.station_code;
	assign invalid_flag  = res.hdr.invalid_flag;
	assign legacy_flag   = res.hdr.legacy_flag;
	assign error_code    = res.error_code;

endmodule

[tb/sv/vfdu_checker.sv]
`timescale 1ns / 1ps

module vfdu_checker
	import vfdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] data_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] sample_value,
	input  logic        last_of_run,
	input  logic        end_of_frame,
	input  logic [29:0] epoch_seconds,
	input  logic [23:0] frame_index,
	input  logic [5:0]  epoch_code,
	input  logic [9:0]  thread_number,
	input  logic [15:0] station_code,
	input  logic        invalid_flag,
	input  logic        legacy_flag,
	input  logic [1:0]  error_code,
	output int          fails,
	output int          pending
);

	// deframer state as seen from the stream
	logic [PosW-1:0]      word_idx;
	logic [PosW-1:0]      frame_len_w;
	logic [WordW-1:0]     hdr_w [4];
	logic                 is_legacy;
	logic                 skipping;
	logic [BpsW-1:0]      bps;
	logic [SampLeftW-1:0] samples_due;
	logic [BufW-1:0]      bitbuf;
	logic [CntW-1:0]      bitcnt;

	res_t awaited[$];
	int   nfail = 0;

	function automatic int unsigned hdr_len();
		return is_legacy ? HdrLegacyLen : HdrFullLen;
	endfunction

	task automatic clear_frame();
		word_idx    = '0;
		skipping    = 1'b0;
		samples_due = '0;
		bitbuf      = '0;
		bitcnt      = '0;
	endtask

	task automatic close_header(input err_t err);
		logic [63:0] pay;
		res_t        r;
		pay = (32'(frame_len_w) > hdr_len()) ? 64'(frame_len_w) - 64'(hdr_len()) : 64'd0;
		skipping    = (err != ERR_NONE);
		samples_due = skipping ? '0 : SampLeftW'((pay * 64'd32) / 64'(bps));
		bitbuf      = '0;
		bitcnt      = '0;
		r = '0;
		r.kind               = skipping ? KIND_ERROR : KIND_HEADER;
		r.last_of_run        = 1'b1;
		r.end_of_frame       = skipping || (samples_due == '0);
		r.hdr.epoch_seconds  = hdr_w[0][29:0];
		r.hdr.frame_index    = hdr_w[1][23:0];
		r.hdr.epoch_code     = hdr_w[1][29:24];
		r.hdr.thread_number  = hdr_w[3][25:16];
		r.hdr.station_code   = hdr_w[3][15:0];
		r.hdr.invalid_flag   = hdr_w[0][31];
		r.hdr.legacy_flag    = hdr_w[0][30];
		r.error_code         = err;
		awaited.push_back(r);
	endtask

	task automatic unpack_payload(input logic [31:0] w);
		logic [63:0] mask;
		res_t        r;
		int          n;
		mask = (64'd1 << bps) - 64'd1;
		bitbuf = bitbuf | (64'(w) << bitcnt);
		bitcnt = bitcnt + 7'd32;
		n = 0;
		while (samples_due != '0 && bitcnt >= 7'(bps) && n < MaxSamplesPerWord) begin
			r = '0;
			r.kind         = KIND_SAMPLE;
			r.sample_value = 32'(bitbuf & mask);
			bitbuf         = bitbuf >> bps;
			bitcnt         = bitcnt - 7'(bps);
			samples_due    = samples_due - 1'b1;
			r.end_of_frame = (samples_due == '0);
			awaited.push_back(r);
			n++;
		end
		if (samples_due == '0) begin
			bitbuf = '0;
			bitcnt = '0;
		end else if (bitcnt > 7'd32) begin
			// rate cap hit: keep only the newest 32 bits
			bitbuf = bitbuf >> (bitcnt - 7'd32);
			bitcnt = 7'd32;
		end
		if (n > 0) begin
			r = awaited.pop_back();
			r.last_of_run = 1'b1;
			awaited.push_back(r);
		end
	endtask

	task automatic deframe_word(input logic [31:0] w);
		int unsigned p;
		int unsigned fend;
		err_t        err;
		p = 32'(word_idx);
		if (p < 4) begin
			hdr_w[p] = w;
			if (p == 0)
				is_legacy = w[30];
			if (p == 2)
				frame_len_w = {w[23:0], 1'b0};
			if (p == 3) begin
				bps = BpsW'(w[30:26]) + 1'b1;
				if (is_legacy) begin
					if (w[31])
						err = ERR_COMPLEX;
					else if (hdr_w[2][28:24] != '0)
						err = ERR_MULTICHAN;
					else
						err = ERR_NONE;
					close_header(err);
				end
			end
		end else if (p == 4 && !is_legacy) begin
			if (hdr_w[3][31])
				err = ERR_COMPLEX;
			else if (hdr_w[2][28:24] != '0)
				err = ERR_MULTICHAN;
			else if (w[31:24] != EdvVersion)
				err = ERR_EDV;
			else
				err = ERR_NONE;
			close_header(err);
		end else if (p >= hdr_len() && !skipping && samples_due != '0) begin
			unpack_payload(w);
		end

		fend = (32'(frame_len_w) > hdr_len()) ? 32'(frame_len_w) : hdr_len();
		if (p >= 3 && p + 1 >= fend)
			clear_frame();
		else
			word_idx = PosW'(p + 1);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			nfail++;
		end
	endtask

	task automatic compare_result();
		res_t r;
		if (awaited.size() == 0) begin
			$error("kind: expected no result, actual %0h", kind);
			nfail++;
			return;
		end
		r = awaited.pop_front();
		check_field("kind", 32'(r.kind), 32'(kind));
		check_field("sample_value", r.sample_value, sample_value);
		check_field("last_of_run", 32'(r.last_of_run), 32'(last_of_run));
		check_field("end_of_frame", 32'(r.end_of_frame), 32'(end_of_frame));
		check_field("epoch_seconds", 32'(r.hdr.epoch_seconds), 32'(epoch_seconds));
		check_field("frame_index", 32'(r.hdr.frame_index), 32'(frame_index));
		check_field("epoch_code", 32'(r.hdr.epoch_code), 32'(epoch_code));
		check_field("thread_number", 32'(r.hdr.thread_number), 32'(thread_number));
		check_field("station_code", 32'(r.hdr.station_code), 32'(station_code));
		check_field("invalid_flag", 32'(r.hdr.invalid_flag), 32'(invalid_flag));
		check_field("legacy_flag", 32'(r.hdr.legacy_flag), 32'(legacy_flag));
		check_field("error_code", 32'(r.error_code), 32'(error_code));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			frame_len_w = '0;
			for (int i = 0; i < 4; i++)
				hdr_w[i] = '0;
			is_legacy = 1'b0;
			bps       = BpsW'(1);
			awaited.delete();
			pending <= 0;
			fails   <= nfail;
		end else begin
			// pop before push: results of this edge's item cannot leave yet
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall)
				deframe_word(data_word);
			pending <= awaited.size();
			fails   <= nfail;
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import vfdu_pkg::*;

	localparam int CycleLimit = 300000;
	localparam int LongHold   = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] data_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [31:0] sample_value;
	logic        last_of_run;
	logic        end_of_frame;
	logic [29:0] epoch_seconds;
	logic [23:0] frame_index;
	logic [5:0]  epoch_code;
	logic [9:0]  thread_number;
	logic [15:0] station_code;
	logic        invalid_flag;
	logic        legacy_flag;
	logic [1:0]  error_code;
	int          fails;
	int          pending;

	bit no_gaps   = 1'b0;
	bit hold_req  = 1'b0;
	int words_sent = 0;
	int cycles     = 0;

	vdif_frame_deframer_unpacker dut (.*);

	vfdu_checker u_checker (.*);

	always #1 clk = ~clk;

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic logic [31:0] payload_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [31:0] w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_word <= w;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// faults: bit 0 complex, bit 1 multichannel, bit 2 bad edv
	task automatic send_frame(input bit leg, input logic [23:0] len, input logic [4:0] bps_m1,
		input logic [2:0] faults, input bit noisy);
		logic [31:0] hw [8];
		int          hlen;
		int          total;
		logic [7:0]  edv;
		for (int i = 0; i < 8; i++)
			hw[i] = $urandom;
		if (!noisy) begin
			hw[0][30]    = leg;
			hw[2][28:24] = '0;
			hw[3][31]    = 1'b0;
			hw[3][30:26] = bps_m1;
			hw[4][31:24] = EdvVersion;
		end
		hw[2][23:0] = len;
		if (faults[0])
			hw[3][31] = 1'b1;
		if (faults[1])
			hw[2][28:24] = 5'($urandom_range(1, 31));
		if (faults[2]) begin
			edv = 8'($urandom_range(0, 254));
			if (edv >= EdvVersion)
				edv = edv + 1'b1;
			hw[4][31:24] = edv;
		end
		hlen  = hw[0][30] ? HdrLegacyLen : HdrFullLen;
		total = (2 * int'(len) > hlen) ? 2 * int'(len) : hlen;
		for (int i = 0; i < total; i++)
			send_word(i < hlen ? hw[i] : payload_word());
	endtask

	// output side: per-item stall draw, with a single long hold-off
	initial begin
		int n;
		forever begin
			if (hold_req) begin
				n = LongHold;
				hold_req = 1'b0;
			end else begin
				n = draw_gap();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int         frame_no;
		bit         leg;
		logic [4:0] bps_m1;
		logic [2:0] faults;
		int         sel;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames
		send_frame(1'b1, 24'd1, 5'd31, 3'b000, 1'b0);   // legacy, too short: header only
		send_frame(1'b1, 24'd2, 5'd4, 3'b011, 1'b0);    // complex wins over multichannel
		send_frame(1'b0, 24'd0, 5'd7, 3'b100, 1'b0);    // bad edv, header-only length
		send_frame(1'b1, 24'd3, 5'd2, 3'b000, 1'b0);    // 3-bit samples across words
		send_frame(1'b0, 24'd5, 5'd0, 3'b000, 1'b0);    // 1-bit samples, full rate
		wait_drained();

		frame_no = 0;
		while (words_sent < 96) begin
			leg = 1'($urandom);
			case ($urandom_range(0, 5))
				0: bps_m1 = 5'd0;
				1: bps_m1 = 5'd31;
				2: bps_m1 = 5'd7;
				default: bps_m1 = 5'($urandom_range(0, 31));
			endcase
			sel = $urandom_range(0, 11);
			case (sel)
				0: faults = 3'b001;
				1: faults = 3'b010;
				2: faults = 3'b100;
				3: faults = 3'($urandom_range(1, 7));
				default: faults = 3'b000;
			endcase
			if (frame_no == 2)
				hold_req = 1'b1;
			if (frame_no == 3)
				wait_drained();
			no_gaps = (frame_no >= 4 && frame_no <= 6);
			send_frame(leg, 24'($urandom_range(0, 9)), bps_m1, faults,
				$urandom_range(0, 7) == 0);
			frame_no++;
		end
		no_gaps = 1'b0;

		// error-free legacy header, mostly ones, with the longest length, cut short after some payload
		send_word(32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF);
		send_word(32'hE0FF_FFFF);
		send_word(32'h7FFF_FFFF);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		send_word(payload_word());
		send_word(payload_word());
		in_valid <= 1'b0;

		wait_drained();
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[vdif_frame_deframer_unpacker.f]
rtl/core/vfdu_pkg.sv
rtl/core/vfdu_fifo.sv
rtl/core/vfdu_front.sv
rtl/core/vfdu_div.sv
rtl/core/vfdu_back.sv
rtl/core/vdif_frame_deframer_unpacker.sv
tb/sv/vfdu_checker.sv
tb/sv/tb_top.sv
